>>> hdl/xrr_pkg.sv
// Package with the constants, types and the state update shared by the random-in-range unit.
package xrr_pkg;

	// Field widths fixed by the item format.
	localparam int unsigned WORD_W         = 64;
	localparam int unsigned HALF_W         = 32;
	localparam int unsigned BOUND_FIELD_W  = 32;
	localparam int unsigned VALUE_W        = 32;
	localparam int unsigned BOUND_WIDTH_DEF = 32;

	// Generator constants.
	localparam logic [WORD_W-1:0] ZERO_STATE_FILL = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [WORD_W-1:0] SCRAMBLE_MULT   = 64'h2545_f491_4f6c_dd1d;
	localparam int unsigned SHIFT_A = 12;
	localparam int unsigned SHIFT_B = 25;
	localparam int unsigned SHIFT_C = 27;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_DIV,
		ST_DONE
	} xrr_state_t;

	// Control that every divider cell sees in the same cycle.
	typedef struct packed {
		logic clr;
		logic en;
		logic take;
	} cell_ctl_t;

	// One generator advance: a zero state is replaced first, then three xor-shifts.
	function automatic logic [WORD_W-1:0] xs_step(input logic [WORD_W-1:0] s);
		logic [WORD_W-1:0] x;
		x = (s == '0) ? ZERO_STATE_FILL : s;
		x = x ^ (x >> SHIFT_A);
		x = x ^ (x << SHIFT_B);
		x = x ^ (x >> SHIFT_C);
		return x;
	endfunction

endpackage

>>> hdl/xrr_bound_if.sv
// Interface for the input channel that carries one bound per item.
interface xrr_bound_if;
	import xrr_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [BOUND_FIELD_W-1:0] bound;

	modport source (output valid, output bound, input ready);
	modport sink (input valid, input bound, output ready);
endinterface

>>> hdl/xrr_result_if.sv
// Interface for the output channel that carries the reduced value and the raw word.
interface xrr_result_if;
	import xrr_pkg::*;

	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	logic [WORD_W-1:0]  raw_word;

	modport source (output valid, output value, output raw_word, input ready);
	modport sink (input valid, input value, input raw_word, output ready);
endinterface

>>> hdl/xrr_div_cell.sv
// One bit slice of the restoring divider: holds one remainder bit and shifts it to its neighbor.
module xrr_div_cell
	import xrr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      shift_in,
	input  logic      div_bit,
	input  logic      borrow_in,
	output logic      r_bit,
	output logic      borrow_out
);

	logic r_q;
	logic diff;

	// Subtract the divisor bit from the shifted remainder bit, borrow ripples upward.
	assign diff       = shift_in ^ div_bit ^ borrow_in;
	assign borrow_out = (~shift_in & div_bit) | (~(shift_in ^ div_bit) & borrow_in);
	assign r_bit      = r_q;

	// Keep the difference when the whole row found no final borrow, else the shifted bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= 1'b0;
		end else if (ctl.clr) begin
			r_q <= 1'b0;
		end else if (ctl.en) begin
			r_q <= ctl.take ? diff : shift_in;
		end
	end

endmodule

>>> hdl/xorshift_random_in_range_unit.sv
// Top level of the xorshift64* random-in-range unit: sequencer, multiplier and divider row.
//
//   channel    dir  handshake      payload
//   cfg        in   cfg_we         cfg_wdata[63:0]  (seed, reloads the generator state)
//   bound_ch   in   valid/ready    bound[31:0]
//   result_ch  out  valid/ready    value[31:0], raw_word[63:0]
//
// A nonzero bound passes through the shared 32x32 multiplier (states MUL0 to MUL3), then the
// bit-slice divider row (one dividend bit per cycle), then the output register load in DONE,
// which waits while an untaken result is held; the next item can be taken in the cycle after.
// A zero bound goes straight from IDLE to DONE, where its all-zero result is loaded.
// One item is worked on at a time; a new item is accepted while a result waits in the output
// register. Reset clears the generator state to zero and empties the output register.
module xorshift_random_in_range_unit
	import xrr_pkg::*;
#(
	parameter int unsigned BOUND_WIDTH = BOUND_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [WORD_W-1:0] cfg_wdata,
	xrr_bound_if.sink         bound_ch,
	xrr_result_if.source      result_ch
);

	// Divisor width, cells in the row and dividend bit counter width.
	localparam int unsigned DW    = (BOUND_WIDTH < BOUND_FIELD_W) ? BOUND_WIDTH : BOUND_FIELD_W;
	localparam int unsigned RW    = DW + 1;
	localparam int unsigned CNT_W = $clog2(WORD_W);

	xrr_state_t state_q, state_d;

	logic [WORD_W-1:0] gen_q;
	logic [WORD_W-1:0] prod_q;
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] acc_hi_sum;
	logic [WORD_W-1:0] dvd_q;
	logic [DW-1:0]     b_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic [VALUE_W-1:0] value_q;
	logic [WORD_W-1:0] raw_q;

	logic [DW-1:0]     b_eff;
	logic              in_fire;
	logic              out_load;
	logic              in_rdy;
	logic              div_en;
	logic [HALF_W-1:0] mul_a;
	logic [HALF_W-1:0] mul_b;
	logic [RW-1:0]     rem;
	logic [RW:0]       bw;
	cell_ctl_t         ctl;

	assign b_eff   = bound_ch.bound[DW-1:0];
	assign in_fire = bound_ch.valid && in_rdy;
	assign bound_ch.ready = in_rdy;

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (bound_ch.valid) begin
					state_d = (b_eff == '0) ? ST_DONE : ST_MUL0;
				end
			end
			ST_MUL0: state_d = ST_MUL1;
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_MUL3;
			ST_MUL3: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || result_ch.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, multiplier operands and divider enable.
	always_comb begin
		in_rdy   = 1'b0;
		out_load = 1'b0;
		div_en   = 1'b0;
		mul_a    = gen_q[HALF_W-1:0];
		mul_b    = SCRAMBLE_MULT[HALF_W-1:0];
		unique case (state_q)
			ST_IDLE: in_rdy = 1'b1;
			ST_MUL0: begin
				mul_a = gen_q[HALF_W-1:0];
				mul_b = SCRAMBLE_MULT[HALF_W-1:0];
			end
			ST_MUL1: begin
				mul_a = gen_q[HALF_W-1:0];
				mul_b = SCRAMBLE_MULT[WORD_W-1:HALF_W];
			end
			ST_MUL2: begin
				mul_a = gen_q[WORD_W-1:HALF_W];
				mul_b = SCRAMBLE_MULT[HALF_W-1:0];
			end
			ST_MUL3: ;
			ST_DIV:  div_en = 1'b1;
			ST_DONE: out_load = !out_valid_q || result_ch.ready;
			default: ;
		endcase
	end

	// Upper half of the product gets each cross term, modulo 2^64.
	assign acc_hi_sum = {acc_q[WORD_W-1:HALF_W] + prod_q[HALF_W-1:0], acc_q[HALF_W-1:0]};

	// Shared 32x32 multiplier with its product registered before accumulation.
	// The operands are zero-extended so that the full product is kept.
	always_ff @(posedge clk) begin
		prod_q <= WORD_W'(mul_a) * WORD_W'(mul_b);
	end

	// Product accumulator, dividend shifter, divisor and bit counter.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			b_q   <= b_eff;
			acc_q <= '0;
		end
		unique case (state_q)
			ST_MUL1: acc_q <= prod_q;
			ST_MUL2: acc_q <= acc_hi_sum;
			ST_MUL3: begin
				acc_q <= acc_hi_sum;
				dvd_q <= acc_hi_sum;
				cnt_q <= CNT_W'(WORD_W - 1);
			end
			ST_DIV: begin
				dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			default: ;
		endcase
	end

	// Generator state: advanced on a nonzero bound, reloaded by a seed write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= '0;
		end else begin
			priority if (cfg_we) begin
				gen_q <= cfg_wdata;
			end else if (in_fire && b_eff != '0) begin
				gen_q <= xs_step(gen_q);
			end
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Row of divider cells; the borrow out of the top cell decides restore or keep.
	assign bw[0]    = 1'b0;
	assign ctl.clr  = in_fire;
	assign ctl.en   = div_en;
	assign ctl.take = ~bw[RW];

	for (genvar i = 0; i < RW; i++) begin : g_cell
		logic sin;
		logic dbit;
		if (i == 0) begin : g_first
			assign sin = dvd_q[WORD_W-1];
		end else begin : g_next
			assign sin = rem[i-1];
		end
		if (i < DW) begin : g_dbit
			assign dbit = b_q[i];
		end else begin : g_top
			assign dbit = 1'b0;
		end
		xrr_div_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.shift_in   (sin),
			.div_bit    (dbit),
			.borrow_in  (bw[i]),
			.r_bit      (rem[i]),
			.borrow_out (bw[i+1])
		);
	end

	// Output register parts the finished result from the next item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			value_q <= VALUE_W'(rem[DW-1:0]);
			raw_q   <= acc_q;
		end
	end

	assign result_ch.valid    = out_valid_q;
	assign result_ch.value    = value_q;
	assign result_ch.raw_word = raw_q;

	// The last dividend bit leads straight to the result state.
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == '0) |=> (state_q == ST_DONE))
		else $error("divider did not finish after the last dividend bit");

	// An advanced state is never zero.
	a_state_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && b_eff != '0 && !cfg_we) |=> (gen_q != '0))
		else $error("generator state became zero after an advance");

	// The remainder handed to the output is below the divisor.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && b_q != '0) |-> (rem[DW-1:0] < b_q && rem[RW-1] == 1'b0))
		else $error("remainder not below the bound");

	// A zero bound gives zero results.
	a_zero_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && b_q == '0) |-> (acc_q == '0 && rem == '0))
		else $error("zero bound gave a nonzero result");

endmodule

>>> test/xrr_draw_checker.sv
// Checker for the random-in-range unit: predicts every draw and compares it with the output.
module xrr_draw_checker
	import xrr_pkg::*;
#(
	parameter int unsigned BOUND_BITS = BOUND_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [WORD_W-1:0] cfg_wdata,
	xrr_bound_if              bound_mon,
	xrr_result_if             result_mon,
	output int unsigned       fail_count,
	output int unsigned       draws_pending,
	output int unsigned       draws_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	// One predicted draw, laid out like the result channel payload.
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [WORD_W-1:0]  raw_word;
	} draw_t;

	// Only the low BOUND_BITS bits of the bound take part in the reduction.
	localparam logic [WORD_W-1:0] BOUND_MASK =
		(BOUND_BITS >= WORD_W) ? '1 : ((64'd1 << BOUND_BITS) - 64'd1);

	logic [WORD_W-1:0] gen_state_model;
	draw_t             pending_draws[$];

	// Generator advance: an all-zero state is swapped for the fill constant first.
	function automatic logic [WORD_W-1:0] xorshift_advance(input logic [WORD_W-1:0] s);
		logic [WORD_W-1:0] x;
		x = (s == '0) ? ZERO_STATE_FILL : s;
		x = x ^ (x >> SHIFT_A);
		x = x ^ (x << SHIFT_B);
		x = x ^ (x >> SHIFT_C);
		return x;
	endfunction

	// A zero bound yields an all-zero draw and leaves the generator alone.
	function automatic draw_t predict_draw(input logic [BOUND_FIELD_W-1:0] bound);
		draw_t             d;
		logic [WORD_W-1:0] divisor;
		divisor = WORD_W'(bound) & BOUND_MASK;
		d = '0;
		if (divisor != '0) begin
			gen_state_model = xorshift_advance(gen_state_model);
			d.raw_word = gen_state_model * SCRAMBLE_MULT;
			d.value = VALUE_W'(d.raw_word % divisor);
		end
		return d;
	endfunction

	// Results are matched before new items are predicted, so a result can never pair with
	// an item accepted at the same edge.
	always @(posedge clk) begin : watch
		draw_t want;
		if (!arst_n) begin
			gen_state_model = '0;
			pending_draws.delete();
		end else begin
			if (result_mon.valid && result_mon.ready) begin
				if (pending_draws.size() == 0) begin
					$display("%0t: unexpected draw value=%h raw_word=%h", $time,
						result_mon.value, result_mon.raw_word);
					fail_count++;
				end else begin
					want = pending_draws.pop_front();
					draws_checked++;
					if (result_mon.value !== want.value) begin
						$display("%0t: value expected %h actual %h", $time, want.value,
							result_mon.value);
						fail_count++;
					end
					if (result_mon.raw_word !== want.raw_word) begin
						$display("%0t: raw_word expected %h actual %h", $time,
							want.raw_word, result_mon.raw_word);
						fail_count++;
					end
				end
			end
			if (cfg_we) begin
				gen_state_model = cfg_wdata;
			end
			if (bound_mon.valid && bound_mon.ready) begin
				pending_draws.push_back(predict_draw(bound_mon.bound));
			end
		end
		draws_pending = pending_draws.size();
	end

endmodule

>>> test/tb_xorshift_random_in_range_unit.sv
// Testbench top for the random-in-range unit: clock, reset, seed loads and bound stimulus.
module tb_xorshift_random_in_range_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import xrr_pkg::*;

	localparam int unsigned PHASES          = 8;
	localparam int unsigned ITEMS_PER_PHASE = 244;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [WORD_W-1:0] cfg_wdata;
	bit                idle_on;
	int unsigned       fail_count;
	int unsigned       draws_pending;
	int unsigned       draws_checked;
	int unsigned       directed_sent;
	int unsigned       random_sent;
	int unsigned       seeds_written;

	xrr_bound_if  bound_ch ();
	xrr_result_if result_ch ();

	xorshift_random_in_range_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.bound_ch  (bound_ch),
		.result_ch (result_ch)
	);

	xrr_draw_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.bound_mon     (bound_ch),
		.result_mon    (result_ch),
		.fail_count    (fail_count),
		.draws_pending (draws_pending),
		.draws_checked (draws_checked)
	);

	// 12 ns clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the handshakes hang.
	initial begin
		#12_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Result side: ready drops in random bursts while idling is on.
	initial begin : result_sink
		int unsigned hold;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 13);
				result_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
		end
	end

	// Mix of zero, tiny, power-of-two, near-full and fully random bounds.
	function automatic logic [BOUND_FIELD_W-1:0] random_bound();
		unique case ($urandom_range(0, 9))
			0: return '0;
			1, 2: return $urandom_range(1, 16);
			3: return 32'd1 << $urandom_range(0, 31);
			4: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	// Offers one bound, with an optional gap before it, and returns at the accepting edge.
	task automatic send_bound(input logic [BOUND_FIELD_W-1:0] b);
		bit took;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			bound_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		bound_ch.valid <= 1'b1;
		bound_ch.bound <= b;
		do begin
			@(negedge clk);
			took = bound_ch.ready;
			@(posedge clk);
		end while (!took);
	endtask

	// Stops offering items and waits until every predicted draw has come back.
	task automatic settle();
		bound_ch.valid <= 1'b0;
		@(posedge clk);
		wait (draws_pending == 0);
		repeat (8) @(posedge clk);
	endtask

	// Loads the seed register; only called while the unit is idle.
	task automatic write_seed(input logic [WORD_W-1:0] s);
		cfg_we <= 1'b1;
		cfg_wdata <= s;
		@(posedge clk);
		cfg_we <= 1'b0;
		seeds_written++;
	endtask

	// Main sequence: directed bounds first, then random phases over several seeds.
	initial begin : stimulus
		logic [BOUND_FIELD_W-1:0] directed_bounds[12];
		logic [WORD_W-1:0]        phase_seeds[PHASES];
		directed_bounds = '{32'h0, 32'h1, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h2,
			32'h3, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE, 32'h0000_FFFF};
		phase_seeds = '{64'h8000_0000_0000_0000, 64'h1, '1, '0,
			{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		bound_ch.valid = 1'b0;
		bound_ch.bound = '0;
		idle_on = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The state is zero after reset: zero bounds must keep it there, and the first
		// real draw starts from the fill constant.
		foreach (directed_bounds[i]) begin
			send_bound(directed_bounds[i]);
			directed_sent++;
		end
		settle();

		// Writing a zero seed brings the zero-state path back; an all-ones seed is the
		// other extreme.
		write_seed('0);
		send_bound(32'h0);
		send_bound(32'hFFFF_FFFF);
		settle();
		write_seed('1);
		send_bound(32'h1);
		send_bound(32'hFFFF_FFFF);
		directed_sent += 4;
		settle();

		// Random phases; one runs without idling, and so does the last.
		for (int p = 0; p < PHASES; p++) begin
			write_seed(phase_seeds[p]);
			idle_on = (p != 3) && (p != PHASES - 1);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_bound(random_bound());
				random_sent++;
			end
			settle();
		end
		idle_on = 1'b0;
		repeat (80) @(posedge clk);

		$display("Run covered %0d directed and %0d random bounds across %0d seed loads.",
			directed_sent, random_sent, seeds_written);
		$display("Draws compared: %0d, field mismatches or strays: %0d.", draws_checked,
			fail_count);
		if (fail_count == 0 && draws_pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
